// ===== rtl/core/ffra_pkg.sv =====
// shared types and constants of the first-fit range allocator
package ffra_pkg;

    localparam int OFF_W      = 24;
    localparam int LEN_W      = OFF_W + 1;
    localparam int SUM_W      = OFF_W + 2;
    localparam int MAX_RANGES = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int GRAN_W     = 5;
    localparam int STAT_W     = 2;

    localparam logic [LEN_W-1:0]  BLOCK_BYTES = LEN_W'(1) << OFF_W;
    localparam logic [GRAN_W-1:0] GRAN_RESET  = GRAN_W'(10);
    // largest granularity whose rounded size can still fit within the whole block
    localparam logic [GRAN_W-1:0] GRAN_MAX    = GRAN_W'(OFF_W);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADSIZE = 2'd3;

    typedef enum logic [2:0] {
        TBL_NOP,
        TBL_SET,
        TBL_DROP,
        TBL_SET_DROP,
        TBL_INSERT
    } t_tbl_op;

    typedef struct packed {
        t_tbl_op           op;
        logic [IDX_W-1:0]  idx;
        logic [OFF_W-1:0]  start;
        logic [LEN_W-1:0]  len;
    } t_tbl_cmd;

endpackage

// ===== rtl/core/ffra_table.sv =====
// free range table: sorted entries with in-place shift on insert and remove
module ffra_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffra_pkg::t_tbl_cmd          i_cmd,
    input  logic [ffra_pkg::IDX_W-1:0]  i_rd_idx,
    output logic [ffra_pkg::OFF_W-1:0]  o_rd_start,
    output logic [ffra_pkg::LEN_W-1:0]  o_rd_len,
    output logic [ffra_pkg::CNT_W-1:0]  o_count
);

    logic [ffra_pkg::OFF_W-1:0] r_start [ffra_pkg::MAX_RANGES];
    logic [ffra_pkg::LEN_W-1:0] r_len   [ffra_pkg::MAX_RANGES];
    logic [ffra_pkg::OFF_W-1:0] n_start [ffra_pkg::MAX_RANGES];
    logic [ffra_pkg::LEN_W-1:0] n_len   [ffra_pkg::MAX_RANGES];
    logic [ffra_pkg::CNT_W-1:0] r_count;
    logic [ffra_pkg::CNT_W-1:0] n_count;

    always_comb begin
        n_start = r_start;
        n_len   = r_len;
        n_count = r_count;
        unique case (i_cmd.op)
            ffra_pkg::TBL_NOP: begin
            end
            ffra_pkg::TBL_SET: begin
                n_start[i_cmd.idx] = i_cmd.start;
                n_len[i_cmd.idx]   = i_cmd.len;
            end
            ffra_pkg::TBL_DROP: begin
                for (int k = 0; k < ffra_pkg::MAX_RANGES - 1; k++) begin
                    if (k >= int'(i_cmd.idx)) begin
                        n_start[k] = r_start[k+1];
                        n_len[k]   = r_len[k+1];
                    end
                end
                n_count = r_count - ffra_pkg::CNT_W'(1);
            end
            ffra_pkg::TBL_SET_DROP: begin
                // write the entry at idx and remove the one after it
                for (int k = 0; k < ffra_pkg::MAX_RANGES - 1; k++) begin
                    if (k > int'(i_cmd.idx)) begin
                        n_start[k] = r_start[k+1];
                        n_len[k]   = r_len[k+1];
                    end
                end
                n_start[i_cmd.idx] = i_cmd.start;
                n_len[i_cmd.idx]   = i_cmd.len;
                n_count = r_count - ffra_pkg::CNT_W'(1);
            end
            ffra_pkg::TBL_INSERT: begin
                for (int k = 1; k < ffra_pkg::MAX_RANGES; k++) begin
                    if (k > int'(i_cmd.idx)) begin
                        n_start[k] = r_start[k-1];
                        n_len[k]   = r_len[k-1];
                    end
                end
                n_start[i_cmd.idx] = i_cmd.start;
                n_len[i_cmd.idx]   = i_cmd.len;
                n_count = r_count + ffra_pkg::CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= ffra_pkg::CNT_W'(1);
            r_start[0] <= '0;
            r_len[0]   <= ffra_pkg::BLOCK_BYTES;
        end else begin
            r_count <= n_count;
            r_start <= n_start;
            r_len   <= n_len;
        end
    end

    assign o_rd_start = r_start[i_rd_idx];
    assign o_rd_len   = r_len[i_rd_idx];
    assign o_count    = r_count;

endmodule

// ===== rtl/core/ffra_ctrl.sv =====
// sequencer: scans the range table one entry per cycle and issues table updates
module ffra_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_action,
    input  logic [ffra_pkg::LEN_W-1:0]   i_size,
    input  logic [ffra_pkg::OFF_W-1:0]   i_offset,
    input  logic [ffra_pkg::GRAN_W-1:0]  i_gran,
    output logic                         o_idle,
    output logic                         o_done,
    input  logic                         i_take,
    output logic [ffra_pkg::STAT_W-1:0]  o_status,
    output logic [ffra_pkg::OFF_W-1:0]   o_alloc_offset,
    output ffra_pkg::t_tbl_cmd           o_tbl_cmd,
    output logic [ffra_pkg::IDX_W-1:0]   o_rd_idx,
    input  logic [ffra_pkg::OFF_W-1:0]   i_rd_start,
    input  logic [ffra_pkg::LEN_W-1:0]   i_rd_len,
    input  logic [ffra_pkg::CNT_W-1:0]   i_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ASCAN,
        S_AUPD,
        S_FSCAN,
        S_FCHK,
        S_FUPD,
        S_DONE
    } t_state;

    t_state                      r_state, n_state;
    logic                        r_action, n_action;
    logic [ffra_pkg::LEN_W-1:0]  r_size, n_size;
    logic [ffra_pkg::OFF_W-1:0]  r_offset, n_offset;
    logic [ffra_pkg::GRAN_W-1:0] r_gran, n_gran;
    logic [ffra_pkg::SUM_W-1:0]  r_end, n_end;
    logic [ffra_pkg::SUM_W-1:0]  r_aligned, n_aligned;
    logic [ffra_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [ffra_pkg::OFF_W-1:0]  r_pstart, n_pstart;
    logic [ffra_pkg::LEN_W-1:0]  r_plen, n_plen;
    logic [ffra_pkg::LEN_W-1:0]  r_pend, n_pend;
    logic [ffra_pkg::LEN_W-1:0]  r_t, n_t;
    logic                        r_pre, n_pre;
    logic                        r_post, n_post;
    logic [ffra_pkg::STAT_W-1:0] r_status, n_status;
    logic [ffra_pkg::OFF_W-1:0]  r_res_off, n_res_off;

    logic [ffra_pkg::SUM_W-1:0]  mask;
    logic [ffra_pkg::SUM_W-1:0]  round_sum;
    logic [ffra_pkg::SUM_W-1:0]  free_end;
    logic                        has_next;
    logic                        has_prev;
    logic                        chk_bad;
    logic                        chk_pre;
    logic                        chk_post;
    logic [ffra_pkg::IDX_W-1:0]  idx_lo;

    always_comb begin
        mask      = (ffra_pkg::SUM_W'(1) << r_gran) - ffra_pkg::SUM_W'(1);
        round_sum = {1'b0, r_size} + mask;
        free_end  = {2'b00, r_offset} + {1'b0, r_size};
        idx_lo    = r_idx[ffra_pkg::IDX_W-1:0];
        has_next  = (r_idx < i_count);
        has_prev  = (r_idx != '0);
        chk_bad   = (has_prev && (r_pend > {1'b0, r_offset}))
                 || (has_next && (r_end > {2'b00, i_rd_start}));
        chk_pre   = has_prev && (r_pend == {1'b0, r_offset});
        chk_post  = has_next && (r_end == {2'b00, i_rd_start});
    end

    always_comb begin
        n_state   = r_state;
        n_action  = r_action;
        n_size    = r_size;
        n_offset  = r_offset;
        n_gran    = r_gran;
        n_end     = r_end;
        n_aligned = r_aligned;
        n_idx     = r_idx;
        n_pstart  = r_pstart;
        n_plen    = r_plen;
        n_pend    = r_pend;
        n_t       = r_t;
        n_pre     = r_pre;
        n_post    = r_post;
        n_status  = r_status;
        n_res_off = r_res_off;
        o_tbl_cmd = '{op: ffra_pkg::TBL_NOP, idx: idx_lo, start: '0, len: '0};

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_action = i_action;
                    n_size   = i_size;
                    n_offset = i_offset;
                    n_gran   = i_gran;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                n_idx     = '0;
                n_res_off = '0;
                n_status  = ffra_pkg::ST_OK;
                if (r_action == ffra_pkg::ACT_ALLOC) begin
                    n_aligned = round_sum & ~mask;
                    if (r_size == '0 || r_size > ffra_pkg::BLOCK_BYTES) begin
                        n_status = ffra_pkg::ST_BADSIZE;
                        n_state  = S_DONE;
                    end else if (r_gran > ffra_pkg::GRAN_MAX) begin
                        // rounded size exceeds the whole block
                        n_status = ffra_pkg::ST_NOFIT;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_ASCAN;
                    end
                end else begin
                    n_end = free_end;
                    if (r_size == '0 || free_end > {1'b0, ffra_pkg::BLOCK_BYTES}) begin
                        n_status = ffra_pkg::ST_BADSIZE;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_FSCAN;
                    end
                end
            end
            S_ASCAN: begin
                if (!has_next) begin
                    n_status = ffra_pkg::ST_NOFIT;
                    n_state  = S_DONE;
                end else if ({1'b0, i_rd_len} >= r_aligned) begin
                    n_res_off = i_rd_start;
                    n_state   = S_AUPD;
                end else begin
                    n_idx = r_idx + ffra_pkg::CNT_W'(1);
                end
            end
            S_AUPD: begin
                if (i_rd_len == r_aligned[ffra_pkg::LEN_W-1:0]) begin
                    o_tbl_cmd.op = ffra_pkg::TBL_DROP;
                end else begin
                    o_tbl_cmd.op    = ffra_pkg::TBL_SET;
                    o_tbl_cmd.start = i_rd_start + r_aligned[ffra_pkg::OFF_W-1:0];
                    o_tbl_cmd.len   = i_rd_len - r_aligned[ffra_pkg::LEN_W-1:0];
                end
                n_state = S_DONE;
            end
            S_FSCAN: begin
                if (has_next && (i_rd_start <= r_offset)) begin
                    n_pstart = i_rd_start;
                    n_plen   = i_rd_len;
                    n_pend   = {1'b0, i_rd_start} + i_rd_len;
                    n_idx    = r_idx + ffra_pkg::CNT_W'(1);
                end else begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                n_pre  = chk_pre;
                n_post = chk_post;
                n_t    = r_size + i_rd_len;
                if (chk_bad) begin
                    n_status = ffra_pkg::ST_BADSIZE;
                    n_state  = S_DONE;
                end else if (!chk_pre && !chk_post
                          && i_count >= ffra_pkg::CNT_W'(ffra_pkg::MAX_RANGES)) begin
                    n_status = ffra_pkg::ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_FUPD;
                end
            end
            S_FUPD: begin
                if (r_pre) begin
                    // merge into the preceding range, swallowing the next if it touches
                    o_tbl_cmd.op    = r_post ? ffra_pkg::TBL_SET_DROP : ffra_pkg::TBL_SET;
                    o_tbl_cmd.idx   = idx_lo - ffra_pkg::IDX_W'(1);
                    o_tbl_cmd.start = r_pstart;
                    o_tbl_cmd.len   = r_plen + (r_post ? r_t : r_size);
                end else if (r_post) begin
                    o_tbl_cmd.op    = ffra_pkg::TBL_SET;
                    o_tbl_cmd.start = r_offset;
                    o_tbl_cmd.len   = r_t;
                end else begin
                    o_tbl_cmd.op    = ffra_pkg::TBL_INSERT;
                    o_tbl_cmd.start = r_offset;
                    o_tbl_cmd.len   = r_size;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_action  <= n_action;
        r_size    <= n_size;
        r_offset  <= n_offset;
        r_gran    <= n_gran;
        r_end     <= n_end;
        r_aligned <= n_aligned;
        r_idx     <= n_idx;
        r_pstart  <= n_pstart;
        r_plen    <= n_plen;
        r_pend    <= n_pend;
        r_t       <= n_t;
        r_pre     <= n_pre;
        r_post    <= n_post;
        r_status  <= n_status;
        r_res_off <= n_res_off;
    end

    assign o_idle         = (r_state == S_IDLE);
    assign o_done         = (r_state == S_DONE);
    assign o_status       = r_status;
    assign o_alloc_offset = r_res_off;
    assign o_rd_idx       = idx_lo;

endmodule

// ===== rtl/core/first_fit_range_allocator.sv =====
// first-fit range allocator: one request in, one status and offset out
// each request scans the range table, at most 16 ranges; a zero or out-of-block size
//   is rejected before the scan
// one request at a time; the next input transfer can come in the cycle after the result
//   moves into the output register
// reset: one free range covering the whole block, granularity_log2 = 10
module first_fit_range_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ffra_pkg::GRAN_W-1:0]   i_cfg_wr_data,   // granularity_log2
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [55:0]                   i_s_axis_tdata,  // req_size[24:0], free_offset[48:25]
    input  logic                          i_s_axis_tuser,  // action
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [23:0]                   o_m_axis_tdata,  // alloc_offset[23:0]
    output logic [ffra_pkg::STAT_W-1:0]   o_m_axis_tuser   // status
);

    logic [ffra_pkg::GRAN_W-1:0] r_gran;
    logic                        r_out_valid;
    logic [ffra_pkg::OFF_W-1:0]  r_out_off;
    logic [ffra_pkg::STAT_W-1:0] r_out_stat;

    logic                        ctl_idle;
    logic                        ctl_done;
    logic                        take;
    logic                        start;
    logic [ffra_pkg::STAT_W-1:0] ctl_status;
    logic [ffra_pkg::OFF_W-1:0]  ctl_off;
    ffra_pkg::t_tbl_cmd          tbl_cmd;
    logic [ffra_pkg::IDX_W-1:0]  rd_idx;
    logic [ffra_pkg::OFF_W-1:0]  rd_start;
    logic [ffra_pkg::LEN_W-1:0]  rd_len;
    logic [ffra_pkg::CNT_W-1:0]  count;

    assign o_s_axis_tready = ctl_idle;
    assign start = i_s_axis_tvalid && ctl_idle;
    // result moves into the output register when it is empty or being drained
    assign take  = ctl_done && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gran      <= ffra_pkg::GRAN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_gran <= i_cfg_wr_data;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (take) begin
            r_out_off  <= ctl_off;
            r_out_stat <= ctl_status;
        end
    end

    ffra_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_action       (i_s_axis_tuser),
        .i_size         (i_s_axis_tdata[24:0]),
        .i_offset       (i_s_axis_tdata[48:25]),
        .i_gran         (r_gran),
        .o_idle         (ctl_idle),
        .o_done         (ctl_done),
        .i_take         (take),
        .o_status       (ctl_status),
        .o_alloc_offset (ctl_off),
        .o_tbl_cmd      (tbl_cmd),
        .o_rd_idx       (rd_idx),
        .i_rd_start     (rd_start),
        .i_rd_len       (rd_len),
        .i_count        (count)
    );

    ffra_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (tbl_cmd),
        .i_rd_idx   (rd_idx),
        .o_rd_start (rd_start),
        .o_rd_len   (rd_len),
        .o_count    (count)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_off;
    assign o_m_axis_tuser  = r_out_stat;

endmodule
